/* src/bdq_pkg.sv */
package bdq_pkg;

    // Default ring depth of the queue.
    localparam int DEPTH_DEF = 64;

    // Width of one stored element.
    localparam int ELEM_W = 32;

    // Request codes carried in the op field.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_SEARCH     = 3'd5
    } bdq_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } bdq_status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_INS_PRIME,
        S_SHIFT,
        S_INS_WR,
        S_SRCH,
        S_FIN_F,
        S_FIN_B,
        S_OUT
    } bdq_state_t;

endpackage

/* src/bounded_deque_with_search.sv */
// Bounded double-ended queue of signed 32-bit values kept in a ring of DEPTH
// slots in a single-port-write, single-port-read memory. Each request (push
// front or back, pop front or back, insert before an index, or search) gives
// exactly one result carrying the status, the count afterwards and the front
// and back values. One request is handled at a time: s_tready is high only
// while the sequencer is idle, and the next request may be taken while the
// previous result still waits on the master side. Every memory access goes
// through one shared ring-address adder (head plus position, wrapped), and
// the memory has one read and one write per cycle, so the cost is set by the
// number of elements that must be touched: a push writes one slot and a pop
// only moves the head or the count, a search reads and compares one element
// per cycle over the whole count, an insert at index i below the count moves
// one element per cycle from the back down to i (read and write overlapped,
// after one priming read) before writing, and an insert that appends writes
// its slot with no move. Errors (full, empty, index beyond count) leave the
// contents unchanged.
module bounded_deque_with_search #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1),
    localparam int FW = $clog2(DEPTH) + 1,
    localparam int SW = ((3 + bdq_pkg::ELEM_W + CW + 7) / 8) * 8,
    localparam int MW = ((3 + FW + CW + 2 * bdq_pkg::ELEM_W + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    // op [2:0], value [34:3], index [CW+34:35], zero fill above
    input  logic [SW-1:0] s_tdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // status [1:0], found [2], found_index, count, front_value, back_value
    output logic [MW-1:0] m_tdata,
    output logic          m_tvalid,
    input  logic          m_tready
);
    import bdq_pkg::*;

    localparam int DW = CW + 1;

    // Element storage.
    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rdata_reg;

    bdq_state_t state_reg, state_next;

    logic [2:0]        op_reg, op_next;
    logic [ELEM_W-1:0] val_reg, val_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     dst_reg, dst_next;
    logic [AW-1:0]     raddr_q_reg;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]     cmp_idx_reg, cmp_idx_next;
    bdq_status_t       status_reg, status_next;
    logic              found_reg, found_next;
    logic [FW-1:0]     fidx_reg, fidx_next;
    logic [ELEM_W-1:0] front_reg, front_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [MW-1:0]     m_tdata_reg, m_tdata_next;

    // Shared ring-address unit and memory port controls.
    logic [CW-1:0] pos;
    logic [DW-1:0] sum;
    logic [AW-1:0] unit_slot;
    logic          mem_we;
    logic [AW-1:0] waddr;
    logic [ELEM_W-1:0] wdata;

    logic          is_full;
    logic          is_empty;
    logic          out_free;
    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] last_pos;
    logic          hit;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Status conditions used by the sequencer.
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign ptr_dec  = ptr_reg - CW'(1);
    assign last_pos = is_empty ? '0 : count_reg - CW'(1);
    assign hit      = cmp_valid_reg && (rdata_reg == val_reg);

    // Ring address: head plus position, folded back once past the end.
    always_comb begin
        sum = DW'(head_reg) + DW'(pos);
        if (sum >= DW'(DEPTH)) begin
            sum = sum - DW'(DEPTH);
        end
        unit_slot = AW'(sum);
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (op_reg == OP_INSERT && !is_full && !(idx_reg > count_reg)) begin
                    state_next = (idx_reg == count_reg) ? S_INS_WR : S_INS_PRIME;
                end else if (op_reg == OP_SEARCH) begin
                    state_next = S_SRCH;
                end else begin
                    state_next = S_FIN_F;
                end
            end
            S_INS_PRIME: state_next = S_SHIFT;
            S_SHIFT: begin
                if (ptr_dec == idx_reg) begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: state_next = S_FIN_F;
            S_SRCH: begin
                if (ptr_reg == count_reg) begin
                    state_next = S_FIN_F;
                end
            end
            S_FIN_F: state_next = S_FIN_B;
            S_FIN_B: state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath control and register updates for each state.
    always_comb begin
        pos            = '0;
        mem_we         = 1'b0;
        waddr          = unit_slot;
        wdata          = val_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        dst_next       = dst_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        front_next     = front_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            S_IDLE: begin
                // Capture the request.
                op_next     = s_tdata[2:0];
                val_next    = s_tdata[3 +: ELEM_W];
                idx_next    = s_tdata[3 + ELEM_W +: CW];
                status_next = STAT_OK;
                found_next  = 1'b0;
                fidx_next   = '1;
            end
            S_EXEC: begin
                case (op_reg)
                    OP_PUSH_FRONT: begin
                        pos = CW'(DEPTH - 1);
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            head_next  = unit_slot;
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_PUSH_BACK: begin
                        pos = count_reg;
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_POP_FRONT: begin
                        pos = CW'(1);
                        if (is_empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            head_next  = unit_slot;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    OP_POP_BACK: begin
                        if (is_empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    OP_INSERT: begin
                        pos = count_reg;
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else if (idx_reg > count_reg) begin
                            status_next = STAT_RANGE;
                        end else begin
                            dst_next = unit_slot;
                            ptr_next = count_reg;
                        end
                    end
                    OP_SEARCH: begin
                        ptr_next       = '0;
                        cmp_valid_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            S_INS_PRIME: begin
                // First read of the element next to the free slot.
                pos = ptr_dec;
            end
            S_SHIFT: begin
                // Move one element a place towards the back, fetch the next.
                pos      = (ptr_dec > idx_reg) ? ptr_reg - CW'(2) : '0;
                mem_we   = 1'b1;
                waddr    = dst_reg;
                wdata    = rdata_reg;
                dst_next = raddr_q_reg;
                ptr_next = ptr_dec;
            end
            S_INS_WR: begin
                pos        = idx_reg;
                mem_we     = 1'b1;
                count_next = count_reg + CW'(1);
            end
            S_SRCH: begin
                // Read one element per cycle and compare it in the next cycle.
                pos = ptr_reg;
                if (ptr_reg < count_reg) begin
                    ptr_next       = ptr_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = ptr_reg;
                end else begin
                    cmp_valid_next = 1'b0;
                end
                if (hit) begin
                    found_next = 1'b1;
                    fidx_next  = FW'(cmp_idx_reg);
                end
            end
            S_FIN_F: begin
                pos = '0;
            end
            S_FIN_B: begin
                pos        = last_pos;
                front_next = rdata_reg;
            end
            S_OUT: begin
                // Hold the back address so the read data stays put.
                pos = last_pos;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = MW'({
                        (is_empty ? ELEM_W'(0) : rdata_reg),
                        (is_empty ? ELEM_W'(0) : front_reg),
                        count_reg,
                        fidx_reg,
                        found_reg,
                        status_reg
                    });
                end
            end
            default: begin
            end
        endcase
    end

    // Element memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[unit_slot];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        ptr_reg     <= ptr_next;
        dst_reg     <= dst_next;
        raddr_q_reg <= unit_slot;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        fidx_reg    <= fidx_next;
        front_reg   <= front_next;
        m_tdata_reg <= m_tdata_next;
    end

    // The element count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond depth");

    // The head slot always stays inside the ring.
    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        DW'(head_reg) < DW'(DEPTH))
        else $error("head slot outside ring");

    // Once a request is taken, no other is taken in the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

    // The count only changes in the states that add or remove elements.
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == S_EXEC || state_reg == S_INS_WR) |=> $stable(count_reg))
        else $error("count changed outside an update state");

    // A new result is only raised from the result state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the result state");

endmodule
